>>> hw/rtl/b64d_pkg.sv
// Shared types and codes for the base64 stream decoder.
`default_nettype none
package b64d_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam logic [15:0] MAX_LENGTH_RESET = 16'd300;
	localparam int REG_MAX_LENGTH = 0;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [1:0]  status;
		logic [15:0] decoded_length;
		logic        last;
	} out_item_t;

	// Results caused by one character: up to three bytes, then an optional status.
	typedef struct packed {
		logic [2:0][7:0] data;
		logic [1:0]      nbytes;
		logic            has_status;
		logic [1:0]      status;
		logic [15:0]     length;
	} bundle_t;

endpackage
`default_nettype wire

>>> hw/rtl/base64_stream_decoder.sv
// Base64 stream decoder top level: APB register, front end, bundle queue, back end.
//
// Input queue side: one character per transfer (push while full is low), with
// end_of_text on the final character of a string. Result queue side: a result
// is presented while empty is low and taken with pop. Each group of four
// symbols yields three data bytes; the final character also yields the tail
// bytes and one status item (code and decoded length, last set).
// Throughput: one character per cycle while full is low; the front end decodes
// a character in the cycle it is accepted and writes its results as one bundle
// into a four-entry queue. The back end emits one result per cycle while the
// receiver pops, so a character that completes a group holds the output for
// its three bytes and, on the final character, its status item. The first
// result of a character is registered in the queue and then in the back end.
// While the receiver stalls, bundles collect in the queue; full rises once
// it holds four bundles, and then every character waits, even one that gives
// no result.
// Reset clears decode state, queue and output; max_length returns to 300.
// max_length sits at byte address 0 of the APB port.
`default_nettype none
module base64_stream_decoder
	import b64d_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        push,
	output logic             full,
	input  wire in_item_t    item,
	output logic             empty,
	input  wire logic        pop,
	output out_item_t        result
);

	logic [15:0] max_length_q;
	logic        reg_sel;
	logic        accept;
	logic        bundle_valid;
	bundle_t     bundle;
	bundle_t     q_head;
	logic        q_empty, q_pop;

	assign pready  = 1'b1;
	assign reg_sel = paddr == 2'(REG_MAX_LENGTH * 4);
	assign prdata  = reg_sel ? {16'd0, max_length_q} : 32'd0;
	assign accept  = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			max_length_q <= pwdata[15:0];
		end
	end

	b64d_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.max_length  (max_length_q),
		.accept      (accept),
		.item        (item),
		.bundle_valid(bundle_valid),
		.bundle      (bundle)
	);

	b64d_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (bundle_valid),
		.wr_data(bundle),
		.rd_en  (q_pop),
		.rd_data(q_head),
		.full   (full),
		.empty  (q_empty)
	);

	b64d_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_head  (q_head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.out_item(result)
	);

endmodule
`default_nettype wire

>>> hw/rtl/b64d_front.sv
// Front end: character classification, sextet packing and length check.
`default_nettype none
module b64d_front
	import b64d_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [15:0] max_length,
	input  wire logic        accept,
	input  wire in_item_t    item,
	output logic             bundle_valid,
	output bundle_t          bundle
);

	localparam int WW = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;

	localparam logic [6:0] SYM_SKIP = 7'd64;
	localparam logic [6:0] SYM_PAD  = 7'd65;
	localparam logic [6:0] SYM_BAD  = 7'd66;

	function automatic logic [6:0] classify(input logic [7:0] ch);
		logic [6:0] s;
		s = SYM_BAD;
		if (ch >= 8'h41 && ch <= 8'h5a) s = 7'(ch - 8'h41);
		else if (ch >= 8'h61 && ch <= 8'h7a) s = 7'(ch - 8'h61 + 8'd26);
		else if (ch >= 8'h30 && ch <= 8'h39) s = 7'(ch - 8'h30 + 8'd52);
		else if (ch == 8'h2b) s = 7'd62;
		else if (ch == 8'h2f) s = 7'd63;
		else if (ch == 8'h0a) s = SYM_SKIP;
		else if (ch == 8'h3d) s = SYM_PAD;
		return s;
	endfunction

	logic [23:0]            gb_q;
	logic [1:0]             sc_q;
	logic [COUNT_WIDTH-1:0] bc_q;
	logic                   pad_q;
	logic [1:0]             err_q;

	logic [6:0]             sym;
	logic                   act, is_sext, grp, tail;
	logic [23:0]            gb_next;
	logic [1:0]             sc_next, err_c, err_f, m, k;
	logic                   pad_c;
	logic [2:0][7:0]        cand;
	logic [WW-1:0]          bc_w, max_w;
	logic                   ok1, ok2, ok3;
	logic [COUNT_WIDTH-1:0] bc_new;
	logic [WW-1:0]          bc_new_w;

	always_comb begin
		sym     = classify(item.char_code);
		act     = (err_q == ST_OK) && !pad_q;
		is_sext = act && !sym[6];
		gb_next = is_sext ? {gb_q[17:0], sym[5:0]} : gb_q;
		grp     = is_sext && (sc_q == 2'd3);
		sc_next = is_sext ? sc_q + 2'd1 : sc_q;
		err_c   = (act && sym == SYM_BAD) ? ST_INVALID : err_q;
		pad_c   = pad_q | (act && sym == SYM_PAD);
		tail    = item.end_of_text && (err_c == ST_OK) && !grp;

		cand = '0;
		m    = 2'd0;
		if (grp) begin
			cand = {gb_next[7:0], gb_next[15:8], gb_next[23:16]};
			m    = 2'd3;
		end else if (tail && sc_next == 2'd3) begin
			cand = {8'd0, gb_next[9:2], gb_next[17:10]};
			m    = 2'd2;
		end else if (tail && sc_next == 2'd2) begin
			cand = {16'd0, gb_next[11:4]};
			m    = 2'd1;
		end

		bc_w  = WW'(bc_q);
		max_w = WW'(max_length);
		ok1   = (bc_w + WW'(1)) <= max_w;
		ok2   = (bc_w + WW'(2)) <= max_w;
		ok3   = (bc_w + WW'(3)) <= max_w;
		if (m >= 2'd3 && ok3) k = 2'd3;
		else if (m >= 2'd2 && ok2) k = 2'd2;
		else if (m >= 2'd1 && ok1) k = 2'd1;
		else k = 2'd0;

		err_f    = (m != k) ? ST_OVERFLOW : err_c;
		bc_new   = bc_q + COUNT_WIDTH'(k);
		bc_new_w = WW'(bc_new);

		bundle.data       = cand;
		bundle.nbytes     = k;
		bundle.has_status = item.end_of_text;
		bundle.status     = err_f;
		bundle.length     = bc_new_w[15:0];
		bundle_valid      = accept && ((k != 2'd0) || item.end_of_text);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gb_q  <= '0;
			sc_q  <= '0;
			bc_q  <= '0;
			pad_q <= 1'b0;
			err_q <= ST_OK;
		end else if (accept) begin
			if (item.end_of_text) begin
				gb_q  <= '0;
				sc_q  <= '0;
				bc_q  <= '0;
				pad_q <= 1'b0;
				err_q <= ST_OK;
			end else begin
				gb_q  <= grp ? 24'd0 : gb_next;
				sc_q  <= sc_next;
				bc_q  <= bc_new;
				pad_q <= pad_c;
				err_q <= err_f;
			end
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/b64d_queue.sv
// Short queue of result bundles between front and back end.
`default_nettype none
module b64d_queue
	import b64d_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    wr_en,
	input  wire bundle_t wr_data,
	input  wire logic    rd_en,
	output bundle_t      rd_data,
	output logic         full,
	output logic         empty
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	bundle_t         mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [PW:0]     count_q;

	assign full    = count_q == (PW+1)'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (rd_en) rd_ptr_q <= rd_ptr_q + PW'(1);
			if (wr_en && !rd_en) count_q <= count_q + (PW+1)'(1);
			else if (rd_en && !wr_en) count_q <= count_q - (PW+1)'(1);
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/b64d_back.sv
// Back end: unrolls each bundle into single result transfers.
`default_nettype none
module b64d_back
	import b64d_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire bundle_t q_head,
	input  wire logic    q_empty,
	output logic         q_pop,
	input  wire logic    pop,
	output logic         empty,
	output out_item_t    out_item
);

	bundle_t    cur_q;
	logic [1:0] idx_q;
	logic       busy_q;

	logic [1:0] last_idx;
	logic       at_end, is_data, advance, load;

	always_comb begin
		last_idx = cur_q.nbytes + {1'b0, cur_q.has_status} - 2'd1;
		at_end   = idx_q == last_idx;
		is_data  = idx_q < cur_q.nbytes;
		advance  = busy_q && pop;
		load     = !busy_q || (advance && at_end);
		q_pop    = load && !q_empty;
		empty    = !busy_q;

		out_item.kind           = is_data ? KIND_DATA : KIND_STATUS;
		out_item.data_byte      = 8'd0;
		if (is_data) begin
			case (idx_q)
				2'd0:    out_item.data_byte = cur_q.data[0];
				2'd1:    out_item.data_byte = cur_q.data[1];
				default: out_item.data_byte = cur_q.data[2];
			endcase
		end
		out_item.status         = is_data ? ST_OK : cur_q.status;
		out_item.decoded_length = is_data ? 16'd0 : cur_q.length;
		out_item.last           = !is_data;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			busy_q <= 1'b0;
		end else if (q_pop) begin
			idx_q  <= '0;
			busy_q <= 1'b1;
		end else if (load) begin
			busy_q <= 1'b0;
		end else if (advance) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule
`default_nettype wire
